>>> hw/rtl/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define AST_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is high.
`define AST_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

>>> hw/rtl/ofe_pkg.sv
package ofe_pkg;

  localparam int DEF_NODE_COUNT     = 65536;
  localparam int DEF_FRONTIER_DEPTH = 4096;
  localparam int DEF_MAX_LEVEL      = 16;

  localparam logic [9:0] LIMIT_RESET = 10'd512;

  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_EXPAND = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_CAP   = 2'd2;
  localparam logic [1:0] ST_BADIX = 2'd3;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [15:0] node_index;
    logic [7:0]  child_mask;
    logic [15:0] child_base;
    logic [11:0] job_number;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [12:0] job_count;
    logic [4:0]  level_reached;
    logic [15:0] job_node;
    logic [15:0] job_x;
    logic [15:0] job_y;
    logic [15:0] job_z;
  } rsp_t;

  // Frontier entry, node in the low bits.
  typedef struct packed {
    logic [15:0] z;
    logic [15:0] y;
    logic [15:0] x;
    logic [15:0] node;
  } job_t;

endpackage

>>> hw/rtl/ofe_ram.sv
module ofe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> hw/rtl/octree_frontier_expander.sv
// Load and unknown requests answer one cycle after acceptance; a read answers after two.
// An expand request takes 8 seed cycles, then per level one check cycle and, for each
// job, 3 memory cycles plus 8 child cycles (one frontier write per cycle), plus 2 at the end.
// One request is in work at a time and the receiver cannot stall; busy is high until the strobe.
// Synchronous reset clears the control state, final count, level and side, and sets
// the limit to 512; the node store and frontiers hold garbage until written.
module octree_frontier_expander #(
  parameter int NODE_COUNT     = ofe_pkg::DEF_NODE_COUNT,
  parameter int FRONTIER_DEPTH = ofe_pkg::DEF_FRONTIER_DEPTH,
  parameter int MAX_LEVEL      = ofe_pkg::DEF_MAX_LEVEL
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  ofe_pkg::req_t request,
  output logic          done,
  output ofe_pkg::rsp_t result,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [9:0]    cfg_data
);
  import ofe_pkg::*;

  localparam int NA  = $clog2(NODE_COUNT);
  localparam int FA  = $clog2(FRONTIER_DEPTH);
  localparam int CAP = FRONTIER_DEPTH / 8;
  localparam int LW  = (FA + 1 > 10) ? FA + 1 : 10;

  localparam logic [FA:0] ONE   = (FA + 1)'(1);
  localparam logic [FA:0] EIGHT = (FA + 1)'(8);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SEED   = 4'd1;
  localparam logic [3:0] S_CHECK  = 4'd2;
  localparam logic [3:0] S_FRD    = 4'd3;
  localparam logic [3:0] S_FWAIT  = 4'd4;
  localparam logic [3:0] S_NWAIT  = 4'd5;
  localparam logic [3:0] S_CHILD  = 4'd6;
  localparam logic [3:0] S_RDWAIT = 4'd7;
  localparam logic [3:0] S_FINISH = 4'd8;

  logic [3:0]  state;
  logic [9:0]  frontier_limit;
  logic [FA:0] final_count;
  logic [4:0]  final_level;
  logic        final_side;

  logic [FA:0] width, nw, idx;
  logic [4:0]  level;
  logic        side;
  logic [1:0]  st;
  logic [2:0]  j;
  logic [3:0]  rank;
  logic [7:0]  mask;
  logic [15:0] base;
  job_t        parent;
  logic        rd_hit;

  logic [LW-1:0] lim_eff;

  // Frontier memory: side bit selects the half.
  logic          f_we;
  logic [FA:0]   f_waddr, f_raddr;
  job_t          f_wdata;
  logic [63:0]   f_rdata;
  job_t          f_job;

  logic          n_we;
  logic [NA-1:0] n_waddr, n_raddr;
  logic [23:0]   n_rdata;

  assign f_job = job_t'(f_rdata);
  assign busy = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign lim_eff = (LW'(frontier_limit) > LW'(CAP)) ? LW'(CAP) : LW'(frontier_limit);

  always_comb begin
    f_we    = 1'b0;
    f_waddr = '0;
    f_wdata = '0;
    f_raddr = {side, FA'(32'(idx))};
    n_we    = 1'b0;
    n_waddr = NA'(32'(request.node_index));
    n_raddr = NA'(32'(f_job.node));
    case (state)
      S_IDLE: begin
        f_raddr = {final_side, FA'(32'(request.job_number))};
        n_we = start && (request.opcode == OP_LOAD)
               && (32'(request.node_index) < NODE_COUNT);
      end
      S_SEED: begin
        f_we    = 1'b1;
        f_waddr = {1'b0, FA'(32'(idx[2:0]))};
        f_wdata = '{z: 16'(idx[2]), y: 16'(idx[1]), x: 16'(idx[0]),
                    node: 16'(idx[2:0]) + 16'd1};
      end
      S_CHILD: begin
        f_we    = mask[j] && (32'(nw) < FRONTIER_DEPTH);
        f_waddr = {~side, FA'(32'(nw))};
        f_wdata = '{z: {parent.z[14:0], j[2]}, y: {parent.y[14:0], j[1]},
                    x: {parent.x[14:0], j[0]}, node: base + 16'(rank)};
      end
      default: ;
    endcase
  end

  ofe_ram #(.WIDTH(64), .DEPTH(2 * FRONTIER_DEPTH)) u_frontier (
    .clk(clk), .we(f_we), .waddr(f_waddr), .wdata(f_wdata),
    .raddr(f_raddr), .rdata(f_rdata)
  );

  ofe_ram #(.WIDTH(24), .DEPTH(NODE_COUNT)) u_nodes (
    .clk(clk), .we(n_we), .waddr(n_waddr), .wdata({request.child_base, request.child_mask}),
    .raddr(n_raddr), .rdata(n_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      done           <= 1'b0;
      frontier_limit <= LIMIT_RESET;
      final_count    <= '0;
      final_level    <= '0;
      final_side     <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        frontier_limit <= cfg_data;
      end
      case (state)
        S_IDLE: begin
          if (start) begin
            result <= '{status: ((request.opcode == OP_LOAD)
                                 && (32'(request.node_index) >= NODE_COUNT))
                                ? ST_BADIX : ST_OK,
                        job_count: 13'(final_count),
                        level_reached: final_level, default: '0};
            case (request.opcode)
              OP_LOAD: done <= 1'b1;
              OP_EXPAND: begin
                idx   <= '0;
                state <= S_SEED;
              end
              OP_READ: begin
                rd_hit <= (32'(request.job_number) < 32'(final_count))
                          && (32'(request.job_number) < FRONTIER_DEPTH);
                state  <= S_RDWAIT;
              end
              default: done <= 1'b1;
            endcase
          end
        end
        S_SEED: begin
          idx <= idx + ONE;
          if (idx[2:0] == 3'd7) begin
            width <= EIGHT;
            level <= 5'd1;
            side  <= 1'b0;
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          idx <= '0;
          nw  <= '0;
          st  <= ST_OK;
          if (width == '0) begin
            st    <= ST_EMPTY;
            state <= S_FINISH;
          end else if (LW'(width) > lim_eff) begin
            state <= S_FINISH;
          end else if (32'(level) >= MAX_LEVEL) begin
            st    <= ST_CAP;
            state <= S_FINISH;
          end else begin
            state <= S_FRD;
          end
        end
        S_FRD: state <= S_FWAIT;
        S_FWAIT: begin
          parent <= f_job;
          if (32'(f_job.node) >= NODE_COUNT) begin
            st    <= ST_BADIX;
            state <= S_FINISH;
          end else begin
            state <= S_NWAIT;
          end
        end
        S_NWAIT: begin
          mask  <= n_rdata[7:0];
          base  <= n_rdata[23:8];
          j     <= '0;
          rank  <= '0;
          state <= S_CHILD;
        end
        S_CHILD: begin
          if (mask[j]) begin
            rank <= rank + 4'd1;
            if (32'(nw) < FRONTIER_DEPTH) begin
              nw <= nw + ONE;
            end
          end
          j <= j + 3'd1;
          if (j == 3'd7) begin
            if (idx + ONE < width) begin
              idx   <= idx + ONE;
              state <= S_FRD;
            end else begin
              side  <= ~side;
              width <= (mask[j] && (32'(nw) < FRONTIER_DEPTH)) ? nw + ONE : nw;
              level <= level + 5'd1;
              state <= S_CHECK;
            end
          end
        end
        S_RDWAIT: begin
          if (rd_hit) begin
            result.job_node <= f_job.node;
            result.job_x    <= f_job.x;
            result.job_y    <= f_job.y;
            result.job_z    <= f_job.z;
          end
          done  <= 1'b1;
          state <= S_IDLE;
        end
        S_FINISH: begin
          final_count <= width;
          final_level <= level;
          final_side  <= side;
          result      <= '{status: st, job_count: 13'(width), level_reached: level,
                           default: '0};
          done        <= 1'b1;
          state       <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

>>> hw/rtl/ofe_checker.sv
`include "assert_macros.svh"

module ofe_checker (
  input logic          clk,
  input logic          rst,
  input logic          start,
  input logic          busy,
  input logic          done,
  input ofe_pkg::rsp_t result
);
  import ofe_pkg::*;

  // An accepted request either answers at once or keeps the block busy.
  `AST_NEXT(a_accept_progress, start && !busy, done || busy)
  // The result strobe always comes while the block is idle.
  `AST_SAME(a_done_not_busy, done, !busy)
  // Without a new request an idle block emits nothing.
  `AST_NEXT(a_no_spurious, !busy && !start, !done)
  // Error results never carry job data.
  `AST_SAME(a_err_no_job, done && (result.status != ST_OK),
            (result.job_node == '0) && (result.job_x == '0)
            && (result.job_y == '0) && (result.job_z == '0))
endmodule

bind octree_frontier_expander ofe_checker u_ofe_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done), .result(result)
);

>>> dv/octree_frontier_expander_tb.sv
`default_nettype none

module octree_frontier_expander_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ofe_pkg::*;

  localparam int LEVEL_CAP = DEF_MAX_LEVEL;
  localparam int WIDTH_CAP = DEF_FRONTIER_DEPTH / 8;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  req_t request;
  logic done;
  rsp_t result;
  logic cfg_valid;
  logic cfg_ready;
  logic [9:0] cfg_data;

  octree_frontier_expander uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .request(request),
    .done(done), .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  // Shadow of the block: node store, final frontier and the limit register.
  logic [23:0] node_mem [bit [15:0]];
  job_t final_jobs[$];
  logic [12:0] final_count;
  logic [4:0] final_level;
  int unsigned frontier_limit;

  rsp_t pending_rsp[$];
  bit failed;
  int items_sent;
  int gap_max;

  typedef struct {
    req_t rq;
    bit typed;
    rsp_t rsp;
  } drow_t;
  drow_t dir_rows[$];

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #2s;
    $display("FAIL");
    $finish;
  end

  // Walks the octree from the level-1 seed. Without commit it only looks for the
  // first node the walk would read that was never loaded and returns it, or -1.
  function automatic int walk_octree(input bit commit, output logic [1:0] st);
    job_t cur[$];
    job_t nxt[$];
    job_t e;
    job_t c;
    int unsigned lim;
    int level;
    logic [23:0] nd;
    logic [15:0] rank;
    bit [2:0] jb;
    lim = (frontier_limit > WIDTH_CAP) ? WIDTH_CAP : frontier_limit;
    st = ST_OK;
    level = 1;
    for (int i = 0; i < 8; i++) begin
      jb = i[2:0];
      c.node = 16'(i + 1);
      c.x = {15'd0, jb[0]};
      c.y = {15'd0, jb[1]};
      c.z = {15'd0, jb[2]};
      cur.push_back(c);
    end
    forever begin
      if (cur.size() == 0) begin
        st = ST_EMPTY;
        break;
      end
      if (cur.size() > lim) break;
      if (level >= LEVEL_CAP) begin
        st = ST_CAP;
        break;
      end
      nxt.delete();
      foreach (cur[i]) begin
        e = cur[i];
        if (!node_mem.exists(e.node)) return int'(e.node);
        nd = node_mem[e.node];
        rank = 0;
        for (int j = 0; j < 8; j++) begin
          if (nd[j]) begin
            jb = j[2:0];
            c.node = nd[23:8] + rank;
            c.x = {e.x[14:0], jb[0]};
            c.y = {e.y[14:0], jb[1]};
            c.z = {e.z[14:0], jb[2]};
            nxt.push_back(c);
            rank++;
          end
        end
      end
      cur = nxt;
      level++;
    end
    if (commit) begin
      final_jobs = cur;
      final_count = 13'(cur.size());
      final_level = 5'(level);
    end
    return -1;
  endfunction

  function automatic rsp_t predict_response(input req_t rq);
    rsp_t r;
    logic [1:0] st;
    int dummy;
    r = '0;
    case (rq.opcode)
      OP_LOAD: node_mem[rq.node_index] = {rq.child_base, rq.child_mask};
      OP_EXPAND: begin
        dummy = walk_octree(1'b1, st);
        r.status = st;
      end
      OP_READ: begin
        if (rq.job_number < final_count) begin
          r.job_node = final_jobs[rq.job_number].node;
          r.job_x = final_jobs[rq.job_number].x;
          r.job_y = final_jobs[rq.job_number].y;
          r.job_z = final_jobs[rq.job_number].z;
        end
      end
      default: ;
    endcase
    r.job_count = final_count;
    r.level_reached = final_level;
    return r;
  endfunction

  task automatic send(input req_t rq, input bit typed, input rsp_t typed_rsp);
    rsp_t r;
    repeat ($urandom_range(0, gap_max)) @(negedge clk);
    start = 1'b1;
    request = rq;
    do @(posedge clk); while (busy);
    r = predict_response(rq);
    pending_rsp.push_back(typed ? typed_rsp : r);
    items_sent++;
    @(negedge clk);
    start = 1'b0;
  endtask

  task automatic send_req(input req_t rq);
    send(rq, 1'b0, '0);
  endtask

  task automatic write_limit(input logic [9:0] v);
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (3) @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data = v;
    do @(posedge clk); while (!cfg_ready);
    frontier_limit = v;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic req_t mk_req(input logic [1:0] op, input logic [15:0] idx,
                                  input logic [7:0] mask, input logic [15:0] base,
                                  input logic [11:0] jn);
    req_t rq;
    rq.opcode = op;
    rq.node_index = idx;
    rq.child_mask = mask;
    rq.child_base = base;
    rq.job_number = jn;
    return rq;
  endfunction

  function automatic void add_row(input req_t rq, input bit typed, input logic [1:0] st,
                                  input int cnt, input int lvl, input logic [15:0] jn,
                                  input logic [15:0] coord);
    drow_t d;
    d.rq = rq;
    d.typed = typed;
    d.rsp = '{status: st, job_count: 13'(cnt), level_reached: 5'(lvl), job_node: jn,
              job_x: coord, job_y: coord, job_z: coord};
    dir_rows.push_back(d);
  endfunction

  // Loads every node the next expansion would read that is still unknown.
  task automatic load_reachable_nodes();
    logic [1:0] st;
    int miss;
    logic [7:0] mask;
    logic [15:0] base;
    forever begin
      miss = walk_octree(1'b0, st);
      if (miss < 0) break;
      mask = ($urandom_range(0, 9) < 4) ? 8'h00 : 8'($urandom);
      base = ($urandom_range(0, 19) == 0) ? 16'($urandom) : 16'($urandom_range(0, 63));
      send_req(mk_req(OP_LOAD, 16'(miss), mask, base, 12'($urandom)));
    end
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_rsp.size() == 0) begin
        $display("%0t: unexpected result %p", $time, result);
        failed = 1'b1;
      end else begin
        if (result !== pending_rsp[0]) begin
          $display("%0t: mismatch expected %p actual %p", $time, pending_rsp[0], result);
          failed = 1'b1;
        end
        void'(pending_rsp.pop_front());
      end
    end
  end

  initial begin
    int k;
    logic [9:0] lim;
    rst = 1'b1;
    start = 1'b0;
    request = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    failed = 1'b0;
    items_sent = 0;
    gap_max = 15;
    final_count = '0;
    final_level = '0;
    frontier_limit = LIMIT_RESET;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    write_limit(10'd1023);

    add_row(mk_req(OP_READ, 0, 0, 0, 0), 1, ST_OK, 0, 0, 0, 0);
    add_row(mk_req(2'd3, 16'hFFFF, 8'hFF, 16'hFFFF, 12'hFFF), 1, ST_OK, 0, 0, 0, 0);
    for (int i = 1; i <= 8; i++) add_row(mk_req(OP_LOAD, 16'(i), 0, 0, 0), 1, ST_OK, 0, 0, 0, 0);
    // Every level-1 node is a leaf, so the frontier empties one level down.
    add_row(mk_req(OP_EXPAND, 0, 0, 0, 0), 1, ST_EMPTY, 0, 2, 0, 0);
    add_row(mk_req(OP_READ, 0, 0, 0, 0), 1, ST_OK, 0, 2, 0, 0);
    // Node 8 points at itself through octant 7, so its corner walks to the level cap.
    add_row(mk_req(OP_LOAD, 8, 8'h80, 8, 0), 1, ST_OK, 0, 2, 0, 0);
    add_row(mk_req(OP_EXPAND, 0, 0, 0, 0), 1, ST_CAP, 1, 16, 0, 0);
    add_row(mk_req(OP_READ, 0, 0, 0, 0), 1, ST_OK, 1, 16, 8, 16'hFFFF);
    add_row(mk_req(OP_READ, 0, 0, 0, 12'hFFF), 1, ST_OK, 1, 16, 0, 0);
    add_row(mk_req(OP_LOAD, 16'hFFFF, 8'hFF, 16'hFFFF, 0), 0, ST_OK, 0, 0, 0, 0);
    add_row(mk_req(OP_LOAD, 8, 8'hFF, 1, 0), 0, ST_OK, 0, 0, 0, 0);
    add_row(mk_req(OP_EXPAND, 0, 0, 0, 0), 0, ST_OK, 0, 0, 0, 0);
    add_row(mk_req(OP_READ, 0, 0, 0, 7), 0, ST_OK, 0, 0, 0, 0);
    add_row(mk_req(OP_LOAD, 1, 8'h01, 16'hFFFF, 0), 0, ST_OK, 0, 0, 0, 0);
    add_row(mk_req(OP_LOAD, 16'hFFFF, 8'h00, 0, 0), 0, ST_OK, 0, 0, 0, 0);
    add_row(mk_req(OP_EXPAND, 0, 0, 0, 0), 0, ST_OK, 0, 0, 0, 0);
    add_row(mk_req(OP_READ, 0, 0, 0, 0), 0, ST_OK, 0, 0, 0, 0);
    foreach (dir_rows[i]) send(dir_rows[i].rq, dir_rows[i].typed, dir_rows[i].rsp);

    // A zero limit stops on the seed frontier itself.
    write_limit(10'd0);
    send_req(mk_req(OP_EXPAND, 0, 0, 0, 0));
    send_req(mk_req(OP_READ, 0, 0, 0, 7));

    while (items_sent < 650) begin
      gap_max = ($urandom_range(0, 3) == 0) ? 0 : 15;
      if ($urandom_range(0, 2) == 0) begin
        k = $urandom_range(0, 9);
        lim = (k == 0) ? 10'd0 : (k == 1) ? 10'd1023 : (k == 2) ? 10'd512 :
              10'($urandom_range(1, 40));
        write_limit(lim);
      end
      // Noise: stray loads anywhere, unknown requests and reads at any position.
      repeat ($urandom_range(0, 3)) begin
        k = $urandom_range(0, 2);
        send_req(mk_req((k == 0) ? OP_LOAD : (k == 1) ? 2'd3 : OP_READ, 16'($urandom),
                        8'($urandom), 16'($urandom), 12'($urandom)));
      end
      load_reachable_nodes();
      send_req(mk_req(OP_EXPAND, 16'($urandom), 8'($urandom), 16'($urandom), 12'($urandom)));
      repeat ($urandom_range(1, 6)) begin
        send_req(mk_req(OP_READ, 16'($urandom), 8'($urandom), 16'($urandom),
                        12'($urandom_range(0, final_count))));
      end
    end

    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (!failed) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
